// ----- src/sap_pkg.sv -----
// Shared constants for the sexagesimal angle text parser.
package sap_pkg;

	// Default degree limit; larger degree values flag the result invalid.
	localparam int DEGREE_LIMIT_DEF = 999;

	// Fraction digits kept. The fraction scaling below assumes three digits.
	localparam int FRACTION_DIGITS = 3;
	localparam int FRAC_LEN_W      = 2;
	localparam int FRAC_W          = 10;

	// Minutes and seconds hold two decimal digits before the range check.
	localparam int MS_W = 7;

	// Result width, in milliarcseconds.
	localparam int ANGLE_W = 33;

	// Phase codes.
	localparam int PH_W = 3;
	localparam logic [PH_W-1:0] PH_LEAD  = 3'd0;
	localparam logic [PH_W-1:0] PH_SIGN  = 3'd1;
	localparam logic [PH_W-1:0] PH_DEG   = 3'd2;
	localparam logic [PH_W-1:0] PH_MIN   = 3'd3;
	localparam logic [PH_W-1:0] PH_SEC   = 3'd4;
	localparam logic [PH_W-1:0] PH_FRAC  = 3'd5;
	localparam logic [PH_W-1:0] PH_TRAIL = 3'd6;

	// Which field a fraction belongs to.
	localparam logic [1:0] OWN_DEG = 2'd0;
	localparam logic [1:0] OWN_MIN = 2'd1;
	localparam logic [1:0] OWN_SEC = 2'd2;

	// Character codes.
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Scale factors to milliarcseconds.
	localparam logic [ANGLE_W-1:0] MAS_PER_DEG = 33'd3600000;
	localparam logic [ANGLE_W-1:0] MAS_PER_MIN = 33'd60000;
	localparam logic [ANGLE_W-1:0] MAS_PER_SEC = 33'd1000;

	// Three-digit fraction (thousandths) of a field, in milliarcseconds per unit.
	localparam logic [ANGLE_W-1:0] FRAC_MAS_DEG = 33'd3600;
	localparam logic [ANGLE_W-1:0] FRAC_MAS_MIN = 33'd60;
	localparam logic [ANGLE_W-1:0] FRAC_MAS_SEC = 33'd1;

	localparam logic [MS_W-1:0] MS_MAX = 7'd59;

	// Snapshot of a finished string, handed to the value stage.
	typedef struct packed {
		logic                ok;
		logic                neg;
		logic [MS_W-1:0]     minutes;
		logic [MS_W-1:0]     seconds;
		logic [FRAC_W-1:0]   frac_milli;
		logic [1:0]          frac_owner;
	} snap_t;

endpackage

// ----- src/sexagesimal_angle_parser_unit.sv -----
// Sexagesimal angle text parser: byte-serial parse and milliarcsecond result.
// Throughput: one text byte per cycle, no bubbles between strings; input stalls
//   only while a finished string waits in the snapshot and the result is stalled.
// Result path: a string's last byte is captured in the snapshot register and then moves
//   on when the result stage can advance (snapshot register -> result register).
// Reset (arst_n low, asynchronous): parser to leading-whitespace phase, both stages empty.
module sexagesimal_angle_parser_unit
	import sap_pkg::*;
#(
	parameter int DEGREE_LIMIT = DEGREE_LIMIT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                text_byte,
	input  logic                      end_of_text,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      parse_ok,
	output logic signed [ANGLE_W-1:0] angle_value
);

	// Degree counter saturates at DEGREE_LIMIT+1, so it needs room for that value.
	localparam int DEG_W = $clog2(DEGREE_LIMIT + 2);
	localparam int DEG_X = DEG_W + 4;  // room for count*10 + digit

	//--------------------------------------------------------------------
	// Parser state
	//--------------------------------------------------------------------
	logic [PH_W-1:0]       phase_q,     phase_n;
	logic                  neg_q,       neg_n;
	logic [DEG_W-1:0]      deg_q,       deg_n;
	logic [MS_W-1:0]       min_q,       min_n;
	logic [MS_W-1:0]       sec_q,       sec_n;
	logic [1:0]            fdc_q,       fdc_n;   // digits seen in current field
	logic [FRAC_W-1:0]     frac_q,      frac_n;
	logic [FRAC_LEN_W-1:0] flen_q,      flen_n;
	logic [1:0]            owner_q,     owner_n;
	logic                  err_q,       err_n;

	// Pipeline: snapshot stage and result stage
	logic                  v_s1;
	snap_t                 snap_s1;
	logic [DEG_W-1:0]      deg_s1;
	logic                  v_s2;
	logic                  ok_s2;
	logic [ANGLE_W-1:0]    value_s2;

	logic                  in_acc;
	logic                  adv_s2;
	logic                  is_blank, is_digit;
	logic [3:0]            digit;
	logic [DEG_X-1:0]      deg_ext;
	logic                  ok_n;
	logic [FRAC_W-1:0]     frac_milli_n;
	snap_t                 snap_n;

	// Result stage moves when empty or drained; input only waits when the
	// snapshot stage is full and cannot move on.
	assign adv_s2   = !v_s2 || !out_stall;
	assign in_stall = v_s1 && !adv_s2;
	assign in_acc   = in_valid && !in_stall;

	assign is_blank = (text_byte inside {[CH_TAB:CH_CR], CH_SPACE});
	assign is_digit = (text_byte inside {[CH_ZERO:CH_NINE]});
	assign digit    = 4'(text_byte - CH_ZERO);
	assign deg_ext  = ({{4{1'b0}}, deg_q} << 3) + ({{4{1'b0}}, deg_q} << 1)
		+ DEG_X'(digit);

	//--------------------------------------------------------------------
	// Next parser state for the incoming byte. Once an error is flagged the
	// rest of the string is ignored.
	//--------------------------------------------------------------------
	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		deg_n   = deg_q;
		min_n   = min_q;
		sec_n   = sec_q;
		fdc_n   = fdc_q;
		frac_n  = frac_q;
		flen_n  = flen_q;
		owner_n = owner_q;
		err_n   = err_q;

		if (!err_q) begin
			if (is_blank) begin
				if (phase_q == PH_LEAD || phase_q == PH_TRAIL) begin
					// skip
				end else if ((phase_q inside {[PH_DEG:PH_FRAC]}) && fdc_q != 2'd0) begin
					phase_n = PH_TRAIL;
				end else begin
					err_n = 1'b1;
				end
			end else if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
				if (phase_q == PH_LEAD) begin
					phase_n = PH_SIGN;
					neg_n   = (text_byte == CH_MINUS);
				end else begin
					err_n = 1'b1;
				end
			end else if (is_digit) begin
				case (phase_q)
					PH_LEAD, PH_SIGN, PH_DEG: begin
						phase_n = PH_DEG;
						if (deg_ext > DEG_X'(DEGREE_LIMIT))
							deg_n = DEG_W'(DEGREE_LIMIT + 1);
						else
							deg_n = deg_ext[DEG_W-1:0];
						if (fdc_q < 2'd2)
							fdc_n = fdc_q + 2'd1;
					end
					PH_MIN, PH_SEC: begin
						if (fdc_q >= 2'd2) begin
							err_n = 1'b1;
						end else begin
							if (phase_q == PH_MIN)
								min_n = MS_W'(min_q * 4'd10) + MS_W'(digit);
							else
								sec_n = MS_W'(sec_q * 4'd10) + MS_W'(digit);
							fdc_n = fdc_q + 2'd1;
						end
					end
					PH_FRAC: begin
						if (flen_q < FRAC_LEN_W'(FRACTION_DIGITS)) begin
							frac_n = FRAC_W'(frac_q * 4'd10) + FRAC_W'(digit);
							flen_n = flen_q + FRAC_LEN_W'(1);
						end
						fdc_n = 2'd1;
					end
					default: err_n = 1'b1;
				endcase
			end else if (text_byte == CH_COLON) begin
				if ((phase_q == PH_DEG || phase_q == PH_MIN) && fdc_q != 2'd0) begin
					phase_n = phase_q + PH_W'(1);
					fdc_n   = 2'd0;
				end else begin
					err_n = 1'b1;
				end
			end else if (text_byte == CH_DOT) begin
				if ((phase_q inside {[PH_DEG:PH_SEC]}) && fdc_q != 2'd0) begin
					owner_n = 2'(phase_q - PH_DEG);
					phase_n = PH_FRAC;
					fdc_n   = 2'd0;
				end else begin
					err_n = 1'b1;
				end
			end else begin
				err_n = 1'b1;
			end
		end
	end

	// Validity of the string as it stands after this byte.
	assign ok_n = !err_n
		&& (phase_n == PH_TRAIL || ((phase_n inside {[PH_DEG:PH_FRAC]}) && fdc_n != 2'd0))
		&& deg_n <= DEG_W'(DEGREE_LIMIT)
		&& min_n <= MS_MAX && sec_n <= MS_MAX;

	// Fraction left-aligned to thousandths; short fractions are padded.
	always_comb begin
		case (flen_n)
			2'd1:    frac_milli_n = FRAC_W'(frac_n * 7'd100);
			2'd2:    frac_milli_n = FRAC_W'(frac_n * 4'd10);
			2'd3:    frac_milli_n = frac_n;
			default: frac_milli_n = '0;
		endcase
	end

	always_comb begin
		snap_n.ok         = ok_n;
		snap_n.neg        = neg_n;
		snap_n.minutes    = min_n;
		snap_n.seconds    = sec_n;
		snap_n.frac_milli = frac_milli_n;
		snap_n.frac_owner = owner_n;
	end

	//--------------------------------------------------------------------
	// Parser state registers: cleared after the last byte of each string.
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
			deg_q   <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			fdc_q   <= '0;
			frac_q  <= '0;
			flen_q  <= '0;
			owner_q <= OWN_DEG;
			err_q   <= 1'b0;
		end else if (in_acc) begin
			if (end_of_text) begin
				phase_q <= PH_LEAD;
				neg_q   <= 1'b0;
				deg_q   <= '0;
				min_q   <= '0;
				sec_q   <= '0;
				fdc_q   <= '0;
				frac_q  <= '0;
				flen_q  <= '0;
				owner_q <= OWN_DEG;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				deg_q   <= deg_n;
				min_q   <= min_n;
				sec_q   <= sec_n;
				fdc_q   <= fdc_n;
				frac_q  <= frac_n;
				flen_q  <= flen_n;
				owner_q <= owner_n;
				err_q   <= err_n;
			end
		end
	end

	//--------------------------------------------------------------------
	// Snapshot stage: fields of a finished string.
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc && end_of_text) begin
			v_s1 <= 1'b1;
		end else if (adv_s2) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && end_of_text) begin
			snap_s1 <= snap_n;
			deg_s1  <= deg_n;
		end
	end

	//--------------------------------------------------------------------
	// Result stage: weighted sum in milliarcseconds, wrapped to 33 bits.
	//--------------------------------------------------------------------
	logic [ANGLE_W-1:0] frac_unit;
	logic [ANGLE_W-1:0] mag;

	always_comb begin
		case (snap_s1.frac_owner)
			OWN_DEG: frac_unit = FRAC_MAS_DEG;
			OWN_MIN: frac_unit = FRAC_MAS_MIN;
			OWN_SEC: frac_unit = FRAC_MAS_SEC;
			default: frac_unit = '0;
		endcase
	end

	assign mag = ANGLE_W'(ANGLE_W'(deg_s1) * MAS_PER_DEG)
		+ ANGLE_W'(ANGLE_W'(snap_s1.minutes) * MAS_PER_MIN)
		+ ANGLE_W'(ANGLE_W'(snap_s1.seconds) * MAS_PER_SEC)
		+ ANGLE_W'(ANGLE_W'(snap_s1.frac_milli) * frac_unit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			ok_s2 <= snap_s1.ok;
			if (!snap_s1.ok)
				value_s2 <= '0;
			else if (snap_s1.neg)
				value_s2 <= ANGLE_W'(0) - mag;
			else
				value_s2 <= mag;
		end
	end

	assign out_valid   = v_s2;
	assign parse_ok    = ok_s2;
	assign angle_value = $signed(value_s2);

endmodule

// ----- test/tb_top.sv -----
// Testbench for the sexagesimal angle text parser: random and directed text against a predictor.
module tb_top
	import sap_pkg::*;
();

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_BYTES = 1400;
	// Cycles with no request and no result moving before the run is declared hung.
	localparam int QUIET_LIMIT  = 4000;
	// Extra time after the last answer, to catch stray results.
	localparam int DRAIN_CYCLES = 8;
	localparam int DEG_LIMIT    = DEGREE_LIMIT_DEF;
	localparam int MS_LIMIT     = 59;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

	// One request: a text byte and its end-of-string mark.
	typedef struct {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	// One predicted answer for a finished string.
	typedef struct {
		logic               ok;
		logic [ANGLE_W-1:0] angle;
	} angle_result_t;

	bit                        clk;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic [7:0]                text_byte   = '0;
	logic                      end_of_text = 1'b0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic                      parse_ok;
	logic signed [ANGLE_W-1:0] angle_value;

	sexagesimal_angle_parser_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.parse_ok   (parse_ok),
		.angle_value(angle_value)
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------
	// Stimulus storage
	// ---------------------------------------------------------------
	text_char_t    text_q[$];        // requests waiting for the driver
	logic [7:0]    draft[$];         // string under construction
	angle_result_t parsed_angles[$]; // answers owed by the block, oldest first
	int            stim_bytes = 0;
	int            mismatches = 0;
	int            quiet_cycles = 0;
	logic          byte_taken = 1'b0;
	logic          finishing = 1'b0;

	// ---------------------------------------------------------------
	// Predictor state: mirrors the parser between strings
	// ---------------------------------------------------------------
	logic [PH_W-1:0] txt_phase  = PH_LEAD;
	logic            txt_neg    = 1'b0;
	logic            txt_bad    = 1'b0;
	int              deg_acc    = 0;   // saturates one past the degree limit
	int              min_acc    = 0;
	int              sec_acc    = 0;
	int              digit_cnt  = 0;   // digits in the open field, capped at 2
	int              frac_acc   = 0;
	int              frac_len   = 0;
	logic [1:0]      frac_field = OWN_DEG;

	function automatic logic is_blank(logic [7:0] b);
		return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
	endfunction

	// Advance the parse by one byte. Once a string is flagged bad, the
	// rest of it is ignored until its last byte.
	task automatic scan_char(logic [7:0] b);
		int d;
		if (is_blank(b)) begin
			// Blanks are free before the number and after it; a blank
			// right after a complete field closes the number.
			if (txt_phase == PH_LEAD || txt_phase == PH_TRAIL)
				;
			else if (txt_phase >= PH_DEG && txt_phase <= PH_FRAC && digit_cnt > 0)
				txt_phase = PH_TRAIL;
			else
				txt_bad = 1'b1;
		end else if (b == CH_PLUS || b == CH_MINUS) begin
			if (txt_phase == PH_LEAD) begin
				txt_phase = PH_SIGN;
				txt_neg   = (b == CH_MINUS);
			end else begin
				txt_bad = 1'b1;
			end
		end else if (b >= CH_ZERO && b <= CH_NINE) begin
			d = b - CH_ZERO;
			if (txt_phase == PH_LEAD || txt_phase == PH_SIGN)
				txt_phase = PH_DEG;
			if (txt_phase == PH_DEG) begin
				deg_acc = deg_acc * 10 + d;
				if (deg_acc > DEG_LIMIT)
					deg_acc = DEG_LIMIT + 1;
				if (digit_cnt < 2)
					digit_cnt++;
			end else if (txt_phase == PH_MIN || txt_phase == PH_SEC) begin
				// Third digit in minutes or seconds is an error.
				if (digit_cnt >= 2) begin
					txt_bad = 1'b1;
				end else begin
					if (txt_phase == PH_MIN)
						min_acc = min_acc * 10 + d;
					else
						sec_acc = sec_acc * 10 + d;
					digit_cnt++;
				end
			end else if (txt_phase == PH_FRAC) begin
				// Digits past the kept precision are dropped, not rounded.
				if (frac_len < FRACTION_DIGITS) begin
					frac_acc = frac_acc * 10 + d;
					frac_len++;
				end
				digit_cnt = 1;
			end else begin
				txt_bad = 1'b1;
			end
		end else if (b == CH_COLON) begin
			if ((txt_phase == PH_DEG || txt_phase == PH_MIN) && digit_cnt > 0) begin
				txt_phase = txt_phase + 1'b1;
				digit_cnt = 0;
			end else begin
				txt_bad = 1'b1;
			end
		end else if (b == CH_DOT) begin
			if (txt_phase >= PH_DEG && txt_phase <= PH_SEC && digit_cnt > 0) begin
				frac_field = 2'(txt_phase - PH_DEG);
				txt_phase  = PH_FRAC;
				digit_cnt  = 0;
			end else begin
				txt_bad = 1'b1;
			end
		end else begin
			txt_bad = 1'b1;
		end
	endtask

	// Last byte seen: work out the answer, queue it, and start over.
	task automatic close_angle();
		angle_result_t res;
		longint        mag;
		longint        frac_part;
		longint        field_mas;
		longint        scale;
		res.ok = !txt_bad &&
		         (txt_phase == PH_TRAIL ||
		          (txt_phase >= PH_DEG && txt_phase <= PH_FRAC && digit_cnt > 0)) &&
		         deg_acc <= DEG_LIMIT && min_acc <= MS_LIMIT && sec_acc <= MS_LIMIT;
		res.angle = '0;
		if (res.ok) begin
			mag = longint'(deg_acc) * longint'(MAS_PER_DEG) +
			      longint'(min_acc) * longint'(MAS_PER_MIN) +
			      longint'(sec_acc) * longint'(MAS_PER_SEC);
			if (frac_len > 0) begin
				field_mas = (frac_field == OWN_DEG) ? longint'(MAS_PER_DEG) :
				            (frac_field == OWN_MIN) ? longint'(MAS_PER_MIN) :
				                                      longint'(MAS_PER_SEC);
				frac_part = frac_acc;
				scale     = 1;
				for (int i = frac_len; i < FRACTION_DIGITS; i++)
					frac_part *= 10;
				for (int i = 0; i < FRACTION_DIGITS; i++)
					scale *= 10;
				// Truncate toward zero on the magnitude, sign comes after.
				mag += frac_part * field_mas / scale;
			end
			if (txt_neg)
				mag = -mag;
			res.angle = mag[ANGLE_W-1:0];
		end
		parsed_angles.push_back(res);
		txt_phase  = PH_LEAD;
		txt_neg    = 1'b0;
		txt_bad    = 1'b0;
		deg_acc    = 0;
		min_acc    = 0;
		sec_acc    = 0;
		digit_cnt  = 0;
		frac_acc   = 0;
		frac_len   = 0;
		frac_field = OWN_DEG;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %0s: got %0d, want %0d (t=%0t)", what, got, want, $time);
		mismatches++;
	endtask

	// ---------------------------------------------------------------
	// String builders
	// ---------------------------------------------------------------
	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			draft.push_back(s[i]);
	endtask

	// Move the draft into the request queue, marking its final byte.
	task automatic seal_text();
		text_char_t ch;
		while (draft.size() > 0) begin
			ch.code = draft.pop_front();
			ch.last = (draft.size() == 0);
			text_q.push_back(ch);
			stim_bytes++;
		end
	endtask

	task automatic push_decimal(int val, int min_digits);
		logic [7:0] digs[$];
		do begin
			digs.push_front(8'(CH_ZERO + val % 10));
			val /= 10;
		end while (val > 0);
		while (digs.size() < min_digits)
			digs.push_front(CH_ZERO);
		foreach (digs[i])
			draft.push_back(digs[i]);
	endtask

	// Any of the six blank codes: tab, LF, VT, FF, CR or space.
	task automatic push_blank();
		int pick;
		pick = $urandom_range(0, 5);
		draft.push_back(pick == 5 ? CH_SPACE : 8'(CH_TAB + pick));
	endtask

	// Minutes or seconds: mostly in range, sometimes 60..99, rarely three digits.
	task automatic push_sub_field();
		int val;
		if ($urandom_range(0, 19) == 0) begin
			push_decimal($urandom_range(0, 999), 3);
		end else begin
			val = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
			push_decimal(val, $urandom_range(1, 2));
		end
	endtask

	// An angle string with random content; some fields may be out of range or too long.
	task automatic build_angle_text();
		int form;
		repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3))
			push_blank();
		case ($urandom_range(0, 3))
			0: draft.push_back(CH_PLUS);
			1: draft.push_back(CH_MINUS);
			default: ;
		endcase
		if ($urandom_range(0, 9) == 0)
			push_decimal($urandom_range(DEG_LIMIT + 1, 99999), 1);
		else if ($urandom_range(0, 4) == 0)
			push_decimal($urandom_range(0, 9), 1);
		else
			push_decimal($urandom_range(0, DEG_LIMIT), $urandom_range(1, 4));
		form = $urandom_range(0, 2);
		if (form >= 1) begin
			draft.push_back(CH_COLON);
			push_sub_field();
		end
		if (form == 2) begin
			draft.push_back(CH_COLON);
			push_sub_field();
		end
		if ($urandom_range(0, 1)) begin
			draft.push_back(CH_DOT);
			repeat ($urandom_range(1, 6))
				draft.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3))
			push_blank();
	endtask

	// Break a draft: overwrite, insert or drop one byte.
	task automatic mangle_text();
		int pos;
		pos = $urandom_range(0, draft.size() - 1);
		case ($urandom_range(0, 2))
			0: draft[pos] = 8'($urandom_range(0, 255));
			1: begin
				case ($urandom_range(0, 5))
					0: draft.insert(pos, CH_COLON);
					1: draft.insert(pos, CH_DOT);
					2: draft.insert(pos, CH_MINUS);
					3: draft.insert(pos, CH_PLUS);
					4: draft.insert(pos, CH_SPACE);
					default: draft.insert(pos, 8'($urandom_range(0, 255)));
				endcase
			end
			default: begin
				if (draft.size() > 1)
					draft.delete(pos);
				else
					draft[pos] = CH_COLON;
			end
		endcase
	endtask

	// Short junk: raw bytes, or bytes from the parser's own alphabet.
	task automatic build_noise_text();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 1)) begin
				draft.push_back(8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 4))
					0: draft.push_back(CH_COLON);
					1: draft.push_back(CH_DOT);
					2: draft.push_back(CH_MINUS);
					3: push_blank();
					default: draft.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
				endcase
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Driver: one request per falling edge when the last one was taken
	// ---------------------------------------------------------------
	int burst_left = 16;
	int gap_left   = 0;

	always @(negedge clk) begin
		text_char_t ch;
		if (arst_n && (!in_valid || byte_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (text_q.size() > 0) begin
				ch = text_q.pop_front();
				text_byte   <= ch.code;
				end_of_text <= ch.last;
				in_valid    <= 1'b1;
				burst_left--;
				// End of burst: a third of the time go straight into the next one.
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result backpressure: modes held for random stretches
	// ---------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	logic [7:0]  stall_word = '0;

	always @(negedge clk) begin
		if (!arst_n || finishing) begin
			out_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 120);
				stall_word = 8'($urandom);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: begin
					out_stall <= stall_word[0];
					stall_word = {stall_word[0], stall_word[7:1]};
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Monitor: predicts on accepted requests, checks accepted results,
	// and runs the hang watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		angle_result_t want;
		logic          moved;
		if (arst_n) begin
			byte_taken = in_valid && !in_stall;
			moved      = byte_taken;
			if (byte_taken) begin
				if (!txt_bad)
					scan_char(text_byte);
				if (end_of_text)
					close_angle();
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (parsed_angles.size() == 0) begin
					report_mismatch("result with none pending", angle_value, 0);
				end else begin
					want = parsed_angles.pop_front();
					if (parse_ok !== want.ok)
						report_mismatch("parse_ok", parse_ok, want.ok);
					if (angle_value !== want.angle)
						report_mismatch("angle_value", angle_value, $signed(want.angle));
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus, reset and end of run
	// ---------------------------------------------------------------
	initial begin
		int random_base;

		// Directed: field extremes, every form, and each error path.
		push_str("0");               seal_text();
		push_str("-0");              seal_text();  // negative zero stays zero
		push_str("+999");            seal_text();
		push_str("1000");            seal_text();  // one past the degree limit
		push_str("99999");           seal_text();  // degree saturation
		push_str("12:34:56.789");    seal_text();
		draft.push_back(CH_TAB);
		push_str("-5:07.5");
		draft.push_back(CH_CR);      seal_text();
		push_str("0.12345");         seal_text();  // extra fraction digits dropped
		push_str("999:59:59.999");   seal_text();
		push_str("-999:59:59.9999"); seal_text();
		push_str("1:2.5");           seal_text();  // fraction of minutes
		push_str("2.25 ");           seal_text();
		push_str("5:60");            seal_text();  // minutes out of range
		push_str("5:123");           seal_text();  // three-digit minutes
		push_str("1:2:60");          seal_text();  // seconds out of range
		push_str("5:");              seal_text();  // empty field
		push_str("5.");              seal_text();
		push_str("-");               seal_text();
		push_str(":3");              seal_text();
		push_str("   ");             seal_text();  // blank only
		push_str("5 3");             seal_text();  // blank inside the number
		push_str("5-");              seal_text();  // sign not first
		push_str("+-1");             seal_text();
		push_str("1:2:3:4");         seal_text();  // extra colon
		draft.push_back(8'hFF);
		push_str("1");               seal_text();  // stray byte

		// Random: mostly well-formed angles, some broken ones, some junk.
		random_base = stim_bytes;
		while (stim_bytes - random_base < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				7, 8: begin
					build_angle_text();
					mangle_text();
				end
				9:       build_noise_text();
				default: build_angle_text();
			endcase
			seal_text();
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every answer to come out.
		while (text_q.size() > 0 || in_valid || parsed_angles.size() > 0)
			@(posedge clk);
		finishing = 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
